/* rtl/core/tlps_pkg.sv */
// ----------------------------------------------------------------------------
// tlps_pkg
// Shared types, sizes and helpers of the two-level preemptive scheduler.
// ----------------------------------------------------------------------------
package tlps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  // wide enough for the last arrival plus every burst of a full table
  localparam int CLK_W     = $clog2((MAX_PROCS + 1) * 65536);
  localparam int TIME_W    = 22;
  localparam int WIDE_W    = (CLK_W > TIME_W) ? CLK_W : TIME_W;
  localparam int DESC_W    = 48;
  localparam int RES_W     = 2 * CLK_W;
  localparam int RES_DEPTH = 2 * (1 << IDX_W);

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] at;
    logic [15:0] bt;
  } desc_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic drop;
    logic sim_init;
    logic fetch;
    logic load_heads;
    logic step;
    logic em_init;
    logic em_rd;
    logic em_calc;
    logic em_next;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic room;
    logic pos_zero;
    logic rd_greater;
    logic is_last;
    logic sim_done;
    logic refetch;
    logic em_last;
  } status_t;

  // clamp a time value to the 22-bit output range
  function automatic logic [TIME_W-1:0] sat_time(input logic [WIDE_W-1:0] v);
    logic [TIME_W-1:0] r;
    if (v > WIDE_W'(TIME_MAX)) r = TIME_MAX;
    else r = v[TIME_W-1:0];
    return r;
  endfunction

endpackage

/* rtl/core/two_level_preemptive_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// two_level_preemptive_scheduler_unit
// Two-level preemptive multilevel-queue scheduler with per-process timing.
// ----------------------------------------------------------------------------
// Descriptors are loaded one item at a time into a system or user queue kept
// stably sorted by arrival; on a load each queue entry with a later arrival
// is read through the registered read port of the queue RAM and moved up one
// slot before the item is placed. A dropped descriptor is not placed. The
// item with last_item set starts the run: a setup step, then one scheduling
// event per step of the controller (a process completion, an idle gap or a
// user preemption), with a fetch of the queue heads after each completion.
// Emission takes a setup step, then each result item is read, computed and
// held until the output accepts it; results come system queue first, then
// user queue, in arrival order, with last_result on the final one. Beyond the
// table capacity descriptors are dropped and table_overflow is set on every
// result of that batch. Input is not taken during the run or the emission.
module two_level_preemptive_scheduler_unit import tlps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        proc_id,
  input  logic [15:0]        arrival,
  input  logic [15:0]        burst,
  input  logic               is_user,
  input  logic               last_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_proc_id,
  output logic               out_is_user,
  output logic [TIME_W-1:0]  completion_time,
  output logic [TIME_W-1:0]  turnaround_time,
  output logic [TIME_W-1:0]  waiting_time,
  output logic [TIME_W-1:0]  response_time,
  output logic               table_overflow,
  output logic               last_result
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  tlps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  // datapath
  tlps_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .proc_id(proc_id), .arrival(arrival), .burst(burst),
    .is_user(is_user), .last_item(last_item),
    .out_proc_id(out_proc_id), .out_is_user(out_is_user),
    .completion_time(completion_time), .turnaround_time(turnaround_time),
    .waiting_time(waiting_time), .response_time(response_time),
    .table_overflow(table_overflow), .last_result(last_result)
  );

endmodule

/* rtl/core/tlps_ram.sv */
// ----------------------------------------------------------------------------
// tlps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tlps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tlps_ctrl.sv */
// ----------------------------------------------------------------------------
// tlps_ctrl
// Sequencer for load, sorted insert, tick simulation and result emission.
// ----------------------------------------------------------------------------
module tlps_ctrl import tlps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_CHK, S_INS_CMP, S_SIM_INIT, S_FETCH, S_LOAD, S_STEP,
    S_EM_INIT, S_EM_RD, S_EM_CALC, S_EM_HOLD
  } state_t;

  state_t state, state_next;

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          state_next  = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (!status.room) begin
          cmd.drop   = 1'b1;
          state_next = status.is_last ? S_SIM_INIT : S_IDLE;
        end else if (status.pos_zero) begin
          cmd.ins_place = 1'b1;
          state_next    = status.is_last ? S_SIM_INIT : S_IDLE;
        end else begin
          cmd.ins_rd = 1'b1;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (status.rd_greater) begin
          cmd.ins_shift = 1'b1;
          state_next    = S_INS_CHK;
        end else begin
          cmd.ins_place = 1'b1;
          state_next    = status.is_last ? S_SIM_INIT : S_IDLE;
        end
      end
      S_SIM_INIT: begin
        cmd.sim_init = 1'b1;
        state_next   = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_heads = 1'b1;
        state_next     = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (status.sim_done) state_next = S_EM_INIT;
        else if (status.refetch) state_next = S_FETCH;
      end
      S_EM_INIT: begin
        cmd.em_init = 1'b1;
        state_next  = S_EM_RD;
      end
      S_EM_RD: begin
        cmd.em_rd  = 1'b1;
        state_next = S_EM_CALC;
      end
      S_EM_CALC: begin
        cmd.em_calc = 1'b1;
        state_next  = S_EM_HOLD;
      end
      S_EM_HOLD: begin
        if (out_ready) begin
          if (status.em_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.em_next = 1'b1;
            state_next  = S_EM_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == S_IDLE);
      out_valid <= (state_next == S_EM_HOLD);
    end
  end

endmodule

/* rtl/core/tlps_dp.sv */
// ----------------------------------------------------------------------------
// tlps_dp
// Queues, schedule registers, time arithmetic and result registers.
// ----------------------------------------------------------------------------
module tlps_dp import tlps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [15:0]        proc_id,
  input  logic [15:0]        arrival,
  input  logic [15:0]        burst,
  input  logic               is_user,
  input  logic               last_item,
  output logic [15:0]        out_proc_id,
  output logic               out_is_user,
  output logic [TIME_W-1:0]  completion_time,
  output logic [TIME_W-1:0]  turnaround_time,
  output logic [TIME_W-1:0]  waiting_time,
  output logic [TIME_W-1:0]  response_time,
  output logic               table_overflow,
  output logic               last_result
);

  // loaded item and insert position
  desc_t            din;
  logic             din_user;
  logic             din_last;
  logic [CNT_W-1:0] pos;

  // control state
  logic [CNT_W-1:0] scnt, ucnt;
  logic             ovf;

  // schedule registers
  logic [CNT_W-1:0] si, ui;
  logic [CLK_W-1:0] sclk;
  desc_t            sh, uh;
  logic [15:0]      urem;
  logic             ustarted;
  logic [CLK_W-1:0] uresp;
  logic             ufresh;

  // emission index
  logic [CNT_W-1:0] eidx;
  logic             ecls;

  // memory ports
  logic [DESC_W-1:0]       sq_rd, uq_rd, q_wdata;
  logic                    sq_we, uq_we;
  logic [IDX_W-1:0]        q_waddr, sq_raddr, uq_raddr;
  logic [RES_W-1:0]        res_rd, res_wdata;
  logic                    res_we;
  logic [IDX_W:0]          res_waddr, res_raddr;

  desc_t            q_sel, e_d;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W:0]   total;

  // step arithmetic
  logic             sys_v, usr_v, sys_go, usr_go, ufin;
  logic [CLK_W-1:0] sh_at, uh_at, gap, run, ct_s, ct_u, resp_s, resp_u, next_at;

  // emission arithmetic
  logic [CLK_W-1:0] e_ct, e_resp, e_tat, e_wt;

  assign q_sel  = din_user ? desc_t'(uq_rd) : desc_t'(sq_rd);
  assign e_d    = ecls ? desc_t'(uq_rd) : desc_t'(sq_rd);
  assign pos_m1 = pos - CNT_W'(1);
  assign total  = {1'b0, scnt} + {1'b0, ucnt};

  // heads and the decision of one step
  always_comb begin
    sh_at  = CLK_W'(sh.at);
    uh_at  = CLK_W'(uh.at);
    sys_v  = (si < scnt);
    usr_v  = (ui < ucnt);
    sys_go = sys_v && (sh_at <= sclk);
    usr_go = usr_v && (uh_at <= sclk);
    gap    = sh_at - sclk;
    run    = CLK_W'(urem);
    if (sys_v && (gap < run)) run = gap;
    ct_s   = sclk + CLK_W'(sh.bt);
    ct_u   = sclk + run;
    resp_s = sclk - sh_at;
    resp_u = ustarted ? uresp : (sclk - uh_at);
    ufin   = (CLK_W'(urem) == run);
    next_at = '1;
    if (sys_v) next_at = sh_at;
    if (usr_v && (uh_at < next_at)) next_at = uh_at;
  end

  // status to the controller
  always_comb begin
    status.room       = (total < (CNT_W + 1)'(MAX_PROCS));
    status.pos_zero   = (pos == '0);
    status.rd_greater = (q_sel.at > din.at);
    status.is_last    = din_last;
    status.sim_done   = !sys_v && !usr_v;
    status.refetch    = sys_go || (usr_go && ufin);
    if (ecls) status.em_last = (eidx == ucnt - CNT_W'(1));
    else status.em_last = (eidx == scnt - CNT_W'(1)) && (ucnt == '0);
  end

  // queue memory ports
  always_comb begin
    q_waddr  = pos[IDX_W-1:0];
    q_wdata  = cmd.ins_shift ? DESC_W'(q_sel) : DESC_W'(din);
    sq_we    = (cmd.ins_shift || cmd.ins_place) && !din_user;
    uq_we    = (cmd.ins_shift || cmd.ins_place) && din_user;
    if (cmd.ins_rd) begin
      sq_raddr = pos_m1[IDX_W-1:0];
      uq_raddr = pos_m1[IDX_W-1:0];
    end else if (cmd.fetch) begin
      sq_raddr = si[IDX_W-1:0];
      uq_raddr = ui[IDX_W-1:0];
    end else begin
      sq_raddr = eidx[IDX_W-1:0];
      uq_raddr = eidx[IDX_W-1:0];
    end
  end

  // result memory ports
  always_comb begin
    res_we    = cmd.step && (sys_go || (usr_go && ufin));
    res_waddr = sys_go ? {1'b0, si[IDX_W-1:0]} : {1'b1, ui[IDX_W-1:0]};
    res_wdata = sys_go ? {resp_s, ct_s} : {resp_u, ct_u};
    res_raddr = {ecls, eidx[IDX_W-1:0]};
  end

  tlps_ram #(.WIDTH(DESC_W), .DEPTH(MAX_PROCS)) u_sysq (
    .clk(clk), .we(sq_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(sq_raddr), .rdata(sq_rd)
  );

  tlps_ram #(.WIDTH(DESC_W), .DEPTH(MAX_PROCS)) u_usrq (
    .clk(clk), .we(uq_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(uq_raddr), .rdata(uq_rd)
  );

  tlps_ram #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .raddr(res_raddr), .rdata(res_rd)
  );

  // emission arithmetic
  always_comb begin
    e_ct   = res_rd[CLK_W-1:0];
    e_resp = res_rd[RES_W-1:CLK_W];
    e_tat  = e_ct - CLK_W'(e_d.at);
    e_wt   = e_tat - CLK_W'(e_d.bt);
  end

  // counts and batch overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      scnt <= '0;
      ucnt <= '0;
      ovf  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        scnt <= '0;
        ucnt <= '0;
        ovf  <= 1'b0;
      end else begin
        if (cmd.drop) ovf <= 1'b1;
        if (cmd.ins_place) begin
          if (din_user) ucnt <= ucnt + CNT_W'(1);
          else scnt <= scnt + CNT_W'(1);
        end
      end
    end
  end

  // loaded item and insert position
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      din      <= '{id: proc_id, at: arrival, bt: burst};
      din_user <= is_user;
      din_last <= last_item;
      pos      <= is_user ? ucnt : scnt;
    end else if (cmd.ins_shift) begin
      pos <= pos_m1;
    end
  end

  // tick simulation
  always_ff @(posedge clk) begin
    if (cmd.sim_init) begin
      si     <= '0;
      ui     <= '0;
      sclk   <= '0;
      ufresh <= 1'b1;
    end
    if (cmd.load_heads) begin
      sh <= desc_t'(sq_rd);
      uh <= desc_t'(uq_rd);
      if (ufresh) begin
        // burst field of the user head
        urem     <= uq_rd[15:0];
        ustarted <= 1'b0;
        ufresh   <= 1'b0;
      end
    end
    if (cmd.step) begin
      if (sys_go) begin
        sclk <= ct_s;
        si   <= si + CNT_W'(1);
      end else if (usr_go) begin
        sclk     <= ct_u;
        urem     <= urem - run[15:0];
        uresp    <= resp_u;
        ustarted <= 1'b1;
        if (ufin) begin
          ui     <= ui + CNT_W'(1);
          ufresh <= 1'b1;
        end
      end else if (sys_v || usr_v) begin
        sclk <= next_at;
      end
    end
  end

  // emission index
  always_ff @(posedge clk) begin
    if (cmd.em_init) begin
      eidx <= '0;
      ecls <= (scnt == '0);
    end else if (cmd.em_next) begin
      if (!ecls && (eidx == scnt - CNT_W'(1))) begin
        eidx <= '0;
        ecls <= 1'b1;
      end else begin
        eidx <= eidx + CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.em_calc) begin
      out_proc_id     <= e_d.id;
      out_is_user     <= ecls;
      completion_time <= sat_time(WIDE_W'(e_ct));
      turnaround_time <= sat_time(WIDE_W'(e_tat));
      waiting_time    <= sat_time(WIDE_W'(e_wt));
      response_time   <= sat_time(WIDE_W'(e_resp));
      table_overflow  <= ovf;
      last_result     <= status.em_last;
    end
  end

endmodule

/* tb/two_level_preemptive_scheduler_unit_tb.sv */
// ----------------------------------------------------------------------------
// two_level_preemptive_scheduler_unit_tb
// Self-checking bench for the two-level scheduler: loads batches of process
// descriptors, predicts the per-process completion, turnaround, waiting and
// response times, and compares every result item in order.
// ----------------------------------------------------------------------------
module two_level_preemptive_scheduler_unit_tb import tlps_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit [15:0] id;
    bit [15:0] at;
    bit [15:0] bt;
  } proc_t;

  typedef struct {
    bit [15:0]       id;
    bit              is_user;
    bit [TIME_W-1:0] ct;
    bit [TIME_W-1:0] tat;
    bit [TIME_W-1:0] wt;
    bit [TIME_W-1:0] rt;
    bit              ovf;
    bit              last;
  } sched_result_t;

  // scoreboard: batch tables, schedule predictor and pending results
  class sched_scoreboard;
    proc_t         sys_q[$];
    proc_t         usr_q[$];
    bit            dropped;
    sched_result_t pending[$];
    int            errors;

    function bit [TIME_W-1:0] clamp(int unsigned v);
      return (v > 32'(TIME_MAX)) ? TIME_MAX : v[TIME_W-1:0];
    endfunction

    // stable insert by arrival
    function void insert_by_arrival(ref proc_t q[$], input proc_t d);
      int pos;
      pos = q.size();
      while (pos > 0 && q[pos-1].at > d.at) pos--;
      q.insert(pos, d);
    endfunction

    // run the tick simulation and queue one result per held process
    function void run_schedule();
      int unsigned now, run, gap, nxt;
      int unsigned rem[2*MAX_PROCS];
      int unsigned resp[2*MAX_PROCS];
      int unsigned comp[2*MAX_PROCS];
      bit          seen[2*MAX_PROCS];
      int          si, ui, slot, k, total;
      sched_result_t r;
      now = 0; si = 0; ui = 0;
      foreach (seen[i]) seen[i] = 0;
      foreach (sys_q[i]) rem[i] = sys_q[i].bt;
      foreach (usr_q[i]) rem[MAX_PROCS+i] = usr_q[i].bt;
      while (si < sys_q.size() || ui < usr_q.size()) begin
        if (si < sys_q.size() && sys_q[si].at <= now) begin
          if (!seen[si]) begin
            seen[si] = 1;
            resp[si] = now - sys_q[si].at;
          end
          now += rem[si];
          comp[si] = now;
          si++;
        end else if (ui < usr_q.size() && usr_q[ui].at <= now) begin
          slot = MAX_PROCS + ui;
          run = rem[slot];
          if (!seen[slot]) begin
            seen[slot] = 1;
            resp[slot] = now - usr_q[ui].at;
          end
          // a user process runs only until the next system arrival
          if (si < sys_q.size()) begin
            gap = sys_q[si].at - now;
            if (gap < run) run = gap;
          end
          now += run;
          rem[slot] -= run;
          if (rem[slot] == 0) begin
            comp[slot] = now;
            ui++;
          end
        end else begin
          nxt = 32'hFFFF_FFFF;
          if (si < sys_q.size()) nxt = sys_q[si].at;
          if (ui < usr_q.size() && usr_q[ui].at < nxt) nxt = usr_q[ui].at;
          now = nxt;
        end
      end
      total = sys_q.size() + usr_q.size();
      k = 0;
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < ((c == 0) ? sys_q.size() : usr_q.size()); i++) begin
          proc_t d;
          d = (c == 0) ? sys_q[i] : usr_q[i];
          slot = c * MAX_PROCS + i;
          k++;
          r.id      = d.id;
          r.is_user = c[0];
          r.ct      = clamp(comp[slot]);
          r.tat     = clamp(comp[slot] - d.at);
          r.wt      = clamp(comp[slot] - d.at - d.bt);
          r.rt      = clamp(resp[slot]);
          r.ovf     = dropped;
          r.last    = (k == total);
          pending.push_back(r);
        end
      end
      sys_q.delete();
      usr_q.delete();
      dropped = 0;
    endfunction

    function void note_descriptor(proc_t d, bit user, bit last);
      if (sys_q.size() + usr_q.size() < MAX_PROCS) begin
        if (user) insert_by_arrival(usr_q, d);
        else insert_by_arrival(sys_q, d);
      end else begin
        dropped = 1;
      end
      if (last) run_schedule();
    endfunction

    function void check_result(sched_result_t a);
      sched_result_t e;
      if (pending.size() == 0) begin
        $error("result with no expectation: id %0h", a.id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.id != e.id) begin
        $error("out_proc_id exp %0h got %0h", e.id, a.id); errors++;
      end
      if (a.is_user != e.is_user) begin
        $error("out_is_user exp %0d got %0d", e.is_user, a.is_user); errors++;
      end
      if (a.ct != e.ct) begin
        $error("completion_time exp %0d got %0d", e.ct, a.ct); errors++;
      end
      if (a.tat != e.tat) begin
        $error("turnaround_time exp %0d got %0d", e.tat, a.tat); errors++;
      end
      if (a.wt != e.wt) begin
        $error("waiting_time exp %0d got %0d", e.wt, a.wt); errors++;
      end
      if (a.rt != e.rt) begin
        $error("response_time exp %0d got %0d", e.rt, a.rt); errors++;
      end
      if (a.ovf != e.ovf) begin
        $error("table_overflow exp %0d got %0d", e.ovf, a.ovf); errors++;
      end
      if (a.last != e.last) begin
        $error("last_result exp %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst = 1;
  logic              in_valid = 0;
  logic              in_ready;
  logic [15:0]       proc_id = 0;
  logic [15:0]       arrival = 0;
  logic [15:0]       burst = 0;
  logic              is_user = 0;
  logic              last_item = 0;
  logic              out_valid;
  logic              out_ready = 0;
  logic [15:0]       out_proc_id;
  logic              out_is_user;
  logic [TIME_W-1:0] completion_time;
  logic [TIME_W-1:0] turnaround_time;
  logic [TIME_W-1:0] waiting_time;
  logic [TIME_W-1:0] response_time;
  logic              table_overflow;
  logic              last_result;

  sched_scoreboard sb = new();
  int  send_idle = 29;
  int  recv_idle = 57;
  int  hold_trigger = 0;
  int  items_sent = 0;
  int  cycles = 0;
  bit  drained = 0;

  two_level_preemptive_scheduler_unit u_top (.*);

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off on request
  int hold_cnt = 0;
  int hold_seen = 0;
  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // result monitor
  always @(posedge clk) begin
    sched_result_t a;
    if (!rst && out_valid && out_ready) begin
      a.id = out_proc_id;   a.is_user = out_is_user;
      a.ct = completion_time; a.tat = turnaround_time;
      a.wt = waiting_time;  a.rt = response_time;
      a.ovf = table_overflow; a.last = last_result;
      sb.check_result(a);
    end
  end

  // drive one descriptor item and wait for its acceptance
  task automatic send_proc(bit [15:0] id, bit [15:0] at, bit [15:0] bt, bit user,
                           bit last);
    proc_t d;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1; proc_id = id; arrival = at; burst = bt;
    is_user = user; last_item = last;
    do @(posedge clk); while (!in_ready);
    d.id = id; d.at = at; d.bt = bt;
    sb.note_descriptor(d, user, last);
    items_sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  // random batch with a chosen spread of arrivals and bursts
  task automatic send_batch();
    int n, amax, bmode;
    bit [15:0] bt;
    n = ($urandom_range(7) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
    case ($urandom_range(2))
      0: amax = 15;
      1: amax = 300;
      default: amax = 65535;
    endcase
    bmode = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      case (bmode)
        0: bt = 16'($urandom_range(8));
        1: bt = 16'($urandom_range(1, 100));
        2: bt = 16'($urandom_range(1, 65535));
        default: bt = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
      endcase
      send_proc(16'($urandom_range(65535)), 16'($urandom_range(amax)), bt,
                1'($urandom_range(1)), i == n - 1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // preemption of a user process, zero bursts, id extremes
    send_proc(16'h0000, 16'd0, 16'd10, 1'b1, 1'b0);
    send_proc(16'hFFFF, 16'd3, 16'd4, 1'b0, 1'b0);
    send_proc(16'h1234, 16'd3, 16'd0, 1'b0, 1'b0);
    send_proc(16'h5678, 16'd1, 16'd0, 1'b1, 1'b0);
    send_proc(16'h00FF, 16'd40, 16'd2, 1'b1, 1'b1);
    // field extremes
    send_proc(16'hAAAA, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_proc(16'h5555, 16'd0, 16'hFFFF, 1'b1, 1'b0);
    send_proc(16'h0001, 16'd0, 16'd1, 1'b1, 1'b1);
    // single item batch
    send_proc(16'h8000, 16'd7, 16'd3, 1'b1, 1'b1);
    // table overflow, last item dropped
    for (int i = 0; i < 18; i++)
      send_proc(16'(i), 16'($urandom_range(20)), 16'($urandom_range(1, 9)),
                1'($urandom_range(1)), i == 17);

    // random batches across idle phases and pressure
    while (items_sent < 300) begin
      if (items_sent >= 130 && items_sent < 240) begin
        send_idle = 57; recv_idle = 29;
      end else if (items_sent >= 240) begin
        send_idle = 0; recv_idle = 0;
      end
      if (items_sent > 60 && hold_trigger == 0) hold_trigger = 1;
      if (items_sent > 180 && !drained) begin
        drained = 1;
        wait (sb.pending.size() == 0);
        repeat (20) @(posedge clk);
      end
      send_batch();
    end

    wait (sb.pending.size() == 0);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
